@@ rtl/emfd_pkg.sv @@
// Shared types and constants for the energy meter frame decoder.
package emfd_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h55;
    localparam logic [7:0] HDR_SECOND  = 8'h5A;
    localparam logic [4:0] LAST_POS    = 5'd21;
    localparam int         STORE_DEPTH = 22;
    localparam logic [23:0] MAX24      = 24'hFFFFFF;

    localparam logic [1:0] REG_MIN_V    = 2'd0;
    localparam logic [1:0] REG_PMARGIN  = 2'd1;
    localparam logic [1:0] REG_CMARGIN  = 2'd2;

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_GARBAGE  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    // Request and reply between the sequencer and the shared divider.
    typedef struct packed {
        logic        start;
        logic [39:0] num;
        logic [23:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [23:0] quo;
    } t_div_rsp;

endpackage

@@ rtl/emfd_divider.sv @@
// Restoring divider, one quotient bit a cycle, saturating to 24 bits.
module emfd_divider
    import emfd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [39:0] r_num;
    logic [24:0] r_rem;
    logic [39:0] r_quo;
    logic [23:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] trial;
    logic [25:0] diff;

    always_comb begin
        trial = {r_rem[23:0], r_num[39]};
        diff  = {1'b0, trial} - {2'b00, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= 6'd40;
            end else if (r_busy) begin
                // shift in next numerator bit, subtract where it fits
                r_num <= {r_num[38:0], 1'b0};
                if (!diff[25]) begin
                    r_rem <= diff[24:0];
                    r_quo <= {r_quo[38:0], 1'b1};
                end else begin
                    r_rem <= trial;
                    r_quo <= {r_quo[38:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_den == '0 || r_quo[39:24] != '0) o_rsp.quo = MAX24;
        else o_rsp.quo = r_quo[23:0];
    end

endmodule

@@ rtl/energy_meter_frame_decoder.sv @@
// Top level of the energy meter serial frame decoder.
// Header and payload bytes: accepted one a cycle, input stays ready throughout a frame.
// Checksum byte of a good frame: three passes through the shared divider
// (launch, start, 40 quotient bits, done), then the multiply and compare states,
// after which the result is offered; a checksum failure is offered the cycle after the last byte.
// Input is held off until the result is taken. Reset (synchronous, active low) clears
// sync state and held values and restores the register defaults.
module energy_meter_frame_decoder
    import emfd_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [23:0] o_voltage_out,
    output logic [23:0] o_current_out,
    output logic [23:0] o_power_out,
    output logic [1:0]  o_frame_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_HUNT, S_SECOND, S_COLLECT, S_DIV_START, S_DIV_WAIT,
        S_MUL_VI, S_MUL_M, S_CHECK, S_OUT
    } t_state;

    t_state r_state;
    logic [4:0]  r_pos;
    logic [7:0]  r_sum;
    logic [7:0]  r_store [STORE_DEPTH];
    logic [1:0]  r_qidx;
    logic [23:0] r_v, r_c, r_p;
    logic [47:0] r_vi;
    logic [55:0] r_pm_vi;
    logic [63:0] r_cm_p;
    logic [15:0] r_min_v;
    logic [7:0]  r_pmargin, r_cmargin;
    logic [23:0] r_hv, r_hc, r_hp;
    logic [1:0]  r_status;
    logic        r_divgo;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic [4:0]  base;
    logic [23:0] num_word, den_word;
    logic [47:0] p_shift;
    logic [39:0] min_shift;
    logic        in_acc;

    emfd_divider u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));

    assign o_cfg_ready = 1'b1;
    assign in_acc = i_valid && o_ready;
    assign o_ready = (r_state == S_HUNT || r_state == S_SECOND || r_state == S_COLLECT);
    assign o_valid = (r_state == S_OUT);
    assign o_voltage_out = r_hv;
    assign o_current_out = r_hc;
    assign o_power_out = r_hp;
    assign o_frame_status = r_status;

    // Pick parameter and period words for the current quotient.
    always_comb begin
        base = 5'(6 * r_qidx);
        num_word = {r_store[base], r_store[base + 5'd1], r_store[base + 5'd2]};
        den_word = {r_store[base + 5'd3], r_store[base + 5'd4], r_store[base + 5'd5]};
        div_req.start = r_divgo;
        div_req.num = 40'({16'd0, num_word} << FRAC_BITS);
        div_req.den = den_word;
        p_shift = 48'({24'd0, r_p} << FRAC_BITS);
        min_shift = 40'({24'd0, r_min_v} << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
            r_pos <= '0;
            r_sum <= '0;
            r_qidx <= '0;
            r_divgo <= 1'b0;
            r_hv <= '0;
            r_hc <= '0;
            r_hp <= '0;
            r_status <= ST_GOOD;
            r_min_v <= 16'd20;
            r_pmargin <= 8'd2;
            r_cmargin <= 8'd10;
        end else begin
            r_divgo <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MIN_V:   r_min_v <= i_cfg_data;
                    REG_PMARGIN: r_pmargin <= i_cfg_data[7:0];
                    REG_CMARGIN: r_cmargin <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_HUNT: if (in_acc && i_rx_byte == HDR_FIRST) r_state <= S_SECOND;
                S_SECOND: if (in_acc) begin
                    if (i_rx_byte == HDR_SECOND) begin
                        r_state <= S_COLLECT;
                        r_pos <= '0;
                        r_sum <= '0;
                    end else if (i_rx_byte != HDR_FIRST) begin
                        r_state <= S_HUNT;
                    end
                end
                S_COLLECT: if (in_acc) begin
                    r_store[r_pos] <= i_rx_byte;
                    if (r_pos != LAST_POS) begin
                        r_sum <= r_sum + i_rx_byte;
                        r_pos <= r_pos + 5'd1;
                    end else if (r_sum != i_rx_byte) begin
                        r_status <= ST_CHECKSUM;
                        r_state <= S_OUT;
                    end else begin
                        r_qidx <= '0;
                        r_state <= S_DIV_START;
                    end
                end
                S_DIV_START: begin
                    r_divgo <= 1'b1;
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: if (div_rsp.done) begin
                    // store quotient, advance to next pair
                    case (r_qidx)
                        2'd0: r_v <= div_rsp.quo;
                        2'd1: r_c <= div_rsp.quo;
                        default: r_p <= div_rsp.quo;
                    endcase
                    if (r_qidx == 2'd2) r_state <= S_MUL_VI;
                    else begin
                        r_qidx <= r_qidx + 2'd1;
                        r_state <= S_DIV_START;
                    end
                end
                S_MUL_VI: begin
                    r_vi <= r_v * r_c;
                    r_cm_p <= 64'(p_shift * r_cmargin);
                    r_state <= S_MUL_M;
                end
                S_MUL_M: begin
                    r_pm_vi <= r_vi * r_pmargin;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    // plausibility: low voltage, excess power, excess current
                    if ({16'd0, r_v} < min_shift
                        || {8'd0, p_shift} > r_pm_vi
                        || {16'd0, r_vi} > r_cm_p) begin
                        r_status <= ST_GARBAGE;
                    end else begin
                        r_status <= ST_GOOD;
                        r_hv <= r_v;
                        r_hc <= r_c;
                        r_hp <= r_p;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) begin
                    r_state <= S_HUNT;
                    r_pos <= '0;
                end
                default: r_state <= S_HUNT;
            endcase
        end
    end

    // Result stays offered with a steady status until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_status))
        else $error("result dropped while stalled");
    // Divider is only started from its launch state.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_divgo |-> $past(r_state) == S_DIV_START)
        else $error("divider started out of sequence");
    // No input taken while a result waits.
    a_no_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready during result");

endmodule

@@ bench/energy_meter_frame_decoder_checker.sv @@
// Checker for the energy meter frame decoder: predicts each frame result and compares.
`timescale 1ns / 100ps
module energy_meter_frame_decoder_checker
    import emfd_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready_in,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_voltage,
    input  logic [23:0] i_current,
    input  logic [23:0] i_power,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_readings,
    output int          o_status_seen
);

    typedef enum logic [1:0] {SEEK_FIRST, SEEK_SECOND, GATHER} t_sync;

    typedef struct packed {
        logic [23:0] volts;
        logic [23:0] amps;
        logic [23:0] watts;
        logic [1:0]  status;
    } t_reading;

    t_reading    readings_due[$];
    t_sync       sync;
    logic [4:0]  pos;
    logic [7:0]  sum;
    logic [7:0]  frame_bytes [STORE_DEPTH];
    logic [23:0] keep_v, keep_c, keep_p;
    logic [15:0] min_volts;
    logic [7:0]  p_margin, c_margin;
    int          fails, got;
    logic [2:0]  seen;

    assign o_fail_count  = fails;
    assign o_pending     = readings_due.size();
    assign o_readings    = got;
    assign o_status_seen = int'(seen);

    function automatic logic [23:0] ratio(int at);
        logic [63:0] num, den, q;
        num = {frame_bytes[at], frame_bytes[at+1], frame_bytes[at+2]};
        num = num << FRAC_BITS;
        den = {frame_bytes[at+3], frame_bytes[at+4], frame_bytes[at+5]};
        if (den == 0) return MAX24;
        q = num / den;
        return (q > 64'hFFFFFF) ? MAX24 : q[23:0];
    endfunction

    task automatic report(input string what, input logic [23:0] seen_v, input logic [23:0] due);
        $display("mismatch %s: got %h, expected %h at %0t", what, seen_v, due, $time);
        fails++;
    endtask

    // Run one accepted byte through the frame tracker.
    task automatic take_byte(input logic [7:0] b);
        logic [23:0] v, c, p;
        logic [127:0] vi, pw;
        logic [1:0]  st;
        case (sync)
            SEEK_SECOND: begin
                if (b == HDR_SECOND) begin
                    sync = GATHER; pos = 0; sum = 0;
                end else sync = (b == HDR_FIRST) ? SEEK_SECOND : SEEK_FIRST;
            end
            GATHER: begin
                frame_bytes[pos] = b;
                if (pos < LAST_POS) begin
                    sum = sum + b;
                    pos++;
                end else begin
                    sync = SEEK_FIRST; pos = 0;
                    if (sum != b) st = ST_CHECKSUM;
                    else begin
                        v = ratio(0); c = ratio(6); p = ratio(12);
                        vi = v * c;
                        pw = {104'd0, p} << FRAC_BITS;
                        if (({112'd0, min_volts} << FRAC_BITS) > v || pw > p_margin * vi
                            || vi > c_margin * pw)
                            st = ST_GARBAGE;
                        else begin
                            st = ST_GOOD; keep_v = v; keep_c = c; keep_p = p;
                        end
                    end
                    readings_due.push_back({keep_v, keep_c, keep_p, st});
                end
            end
            default: sync = (b == HDR_FIRST) ? SEEK_SECOND : SEEK_FIRST;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_reading due;
        if (!i_rst_n) begin
            sync = SEEK_FIRST; pos = 0; sum = 0;
            keep_v = 0; keep_c = 0; keep_p = 0;
            min_volts = 20; p_margin = 2; c_margin = 10;
            readings_due.delete();
            fails = 0; got = 0; seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MIN_V:   min_volts = i_cfg_data;
                    REG_PMARGIN: p_margin = i_cfg_data[7:0];
                    REG_CMARGIN: c_margin = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got++;
                if (readings_due.size() == 0) begin
                    $display("unexpected reading at %0t", $time);
                    fails++;
                end else begin
                    due = readings_due.pop_front();
                    seen[i_status] = 1'b1;
                    if (i_voltage !== due.volts) report("voltage", i_voltage, due.volts);
                    if (i_current !== due.amps) report("current", i_current, due.amps);
                    if (i_power !== due.watts) report("power", i_power, due.watts);
                    if (i_status !== due.status)
                        report("status", 24'(i_status), 24'(due.status));
                end
            end
            if (i_valid && i_ready_in) take_byte(i_rx_byte);
        end
    end

endmodule

@@ bench/energy_meter_frame_decoder_tb.sv @@
// Testbench top for the energy meter frame decoder: stimulus, back pressure and verdict.
`timescale 1ns / 100ps
module energy_meter_frame_decoder_tb;
    import emfd_pkg::*;

    localparam int  FRAC_BITS = 8;
    localparam int  CYCLE_LIMIT = 900000;
    // Drain margin after the queue empties; the longest path is a good frame through the divider.
    localparam int  DRAIN_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [23:0] o_voltage_out, o_current_out, o_power_out;
    logic [1:0]  o_frame_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data = 16'd0;

    int  fail_count, pending, readings, status_seen;
    int  cycles = 0;
    int  bytes_sent = 0;
    bit  calm = 1'b0;      // no idling on either side while set
    bit  hold_off = 1'b0;  // receiver stalls completely while set
    logic [7:0] frame [24];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    energy_meter_frame_decoder #(.FRAC_BITS(FRAC_BITS)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_rx_byte(i_rx_byte),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_voltage_out(o_voltage_out), .o_current_out(o_current_out),
        .o_power_out(o_power_out), .o_frame_status(o_frame_status),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    energy_meter_frame_decoder_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_rx_byte(i_rx_byte),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_voltage(o_voltage_out), .i_current(o_current_out),
        .i_power(o_power_out), .i_status(o_frame_status),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_readings(readings), .o_status_seen(status_seen)
    );

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stalls, none in calm stretches, all during hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) i_ready <= 1'b0;
        else if (calm) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(99) >= 34);
    end

    // Offer one byte; hold it steady until the transaction completes.
    // Valid is left high on return so bytes can follow back to back.
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        if (!calm) begin
            while ($urandom_range(99) < 34) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        // ready is steady from the falling edge up to the next rising edge
        do begin
            taken = o_ready;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (!taken);
        bytes_sent++;
    endtask

    // Write one register; callers use it once the decoder has gone quiet.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            taken = o_cfg_ready;
            @(posedge i_clk);
            @(negedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Build a frame from three parameter/period pairs; optionally spoil the checksum.
    task automatic build_frame(input logic [23:0] w [6], input bit bad_sum);
        logic [7:0] s;
        s = 0;
        frame[0] = HDR_FIRST;
        frame[1] = HDR_SECOND;
        for (int i = 0; i < 6; i++) begin
            frame[2 + 3*i] = w[i][23:16];
            frame[3 + 3*i] = w[i][15:8];
            frame[4 + 3*i] = w[i][7:0];
        end
        frame[20] = 8'($urandom); frame[21] = 8'($urandom); frame[22] = 8'($urandom);
        for (int i = 2; i < 23; i++) s = s + frame[i];
        frame[23] = bad_sum ? s ^ (8'd1 << $urandom_range(7)) : s;
    endtask

    task automatic send_frame();
        for (int i = 0; i < 24; i++) send_byte(frame[i]);
    endtask

    // Plausible reading: V between 20 and 250 with random shape, P set near V*I on a random half.
    task automatic plausible_words(output logic [23:0] w [6]);
        logic [23:0] pv, pc;
        pv = 24'($urandom_range(16'hFFFF, 1));
        pc = 24'($urandom_range(16'hFFFF, 1));
        w[0] = 24'(pv * $urandom_range(250, 20));
        w[1] = pv;
        w[2] = 24'(pc * $urandom_range(20, 1));
        w[3] = pc;
        w[4] = 24'(w[0][23:8] * w[2][23:8] / 16'hFFFF + 1);
        w[5] = 24'($urandom_range(24'hFFFFFF, 1));
        if ($urandom_range(1)) begin
            // Align power to V*I closely so the margin tests pass whenever both margins are nonzero.
            w[4] = 24'((w[0] / w[1]) * (w[2] / w[3]));
            w[5] = 24'd1;
        end
    endtask

    task automatic random_words(output logic [23:0] w [6]);
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(5))
                0: w[i] = 24'd0;
                1: w[i] = 24'hFFFFFF;
                2: w[i] = 24'($urandom_range(255));
                default: w[i] = 24'($urandom);
            endcase
        end
    endtask

    logic [23:0] words [6];

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: broken headers, repeated first byte, garbage bytes.
        calm = 1'b1;
        send_byte(8'h00); send_byte(HDR_FIRST); send_byte(8'h12);
        send_byte(HDR_FIRST); send_byte(HDR_FIRST); send_byte(8'hFF);
        // Good reading: V=230, I=5, P=1150, all periods one.
        words = '{24'd230, 24'd1, 24'd5, 24'd1, 24'd1150, 24'd1};
        build_frame(words, 0); send_frame();
        // Zero period and overflow saturate.
        words = '{24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd1, 24'd0, 24'd0};
        build_frame(words, 0); send_frame();
        // Checksum error keeps the held reading.
        build_frame(words, 1); send_frame();
        settle();

        // Extreme register settings, then defaults with a write to the unused index, each followed by frames.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_MIN_V, 16'd0);
                    write_reg(REG_PMARGIN, 16'd0);
                    write_reg(REG_CMARGIN, 16'd255);
                end
                1: begin
                    write_reg(REG_MIN_V, 16'hFFFF);
                    write_reg(REG_PMARGIN, 16'd255);
                    write_reg(REG_CMARGIN, 16'd0);
                end
                2: begin
                    write_reg(REG_MIN_V, 16'd1);
                    write_reg(REG_PMARGIN, 16'd255);
                    write_reg(REG_CMARGIN, 16'd255);
                end
                default: begin
                    write_reg(REG_MIN_V, 16'd20);
                    write_reg(REG_PMARGIN, 16'd2);
                    write_reg(REG_CMARGIN, 16'd10);
                    write_reg(2'd3, 16'hABCD);
                end
            endcase
            calm = (phase == 2);
            for (int f = 0; f < 4; f++) begin
                if ($urandom_range(3) == 0) random_words(words);
                else plausible_words(words);
                build_frame(words, $urandom_range(9) == 0);
                send_frame();
                // Line noise between frames, sometimes a stray header byte.
                repeat ($urandom_range(3))
                    send_byte($urandom_range(1) ? HDR_FIRST : 8'($urandom));
            end
            settle();
        end

        // Long receiver hold-off while bytes keep coming.
        calm = 1'b0;
        hold_off = 1'b1;
        fork
            begin
                repeat (2000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int f = 0; f < 4; f++) begin
                    plausible_words(words); build_frame(words, 0); send_frame();
                end
            end
        join
        settle();

        // Main random stretch: mostly valid frames, some broken ones and noise.
        write_reg(REG_MIN_V, 16'($urandom_range(40)));
        write_reg(REG_PMARGIN, 16'($urandom_range(255, 1)));
        write_reg(REG_CMARGIN, 16'($urandom_range(255, 1)));
        while (bytes_sent < 750) begin
            case ($urandom_range(9))
                0: begin
                    // Truncated frame: header and a few bytes, then a new attempt.
                    random_words(words); build_frame(words, 0);
                    for (int i = 0; i < 2 + $urandom_range(10); i++) send_byte(frame[i]);
                end
                1: send_byte(8'($urandom));
                2: begin random_words(words); build_frame(words, $urandom_range(1)); send_frame(); end
                default: begin plausible_words(words); build_frame(words, 0); send_frame(); end
            endcase
        end
        settle();

        $display("%0d bytes sent, %0d readings checked, status codes seen mask %b",
                 bytes_sent, readings, 3'(status_seen));
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/emfd_pkg.sv
rtl/emfd_divider.sv
rtl/energy_meter_frame_decoder.sv
bench/energy_meter_frame_decoder_checker.sv
bench/energy_meter_frame_decoder_tb.sv
